/* design/drbq_pkg.sv */
// Package for the dual reader broadcast queue.
// Holds command and status codes, the controller state type and
// the command and status structs shared by the controller and the datapath.
`timescale 1ns / 1ps

package drbq_pkg;

   localparam int SLOTS_DEFAULT = 8;

   localparam logic [1:0] CMD_SEND  = 2'd0;
   localparam logic [1:0] CMD_READ1 = 2'd1;
   localparam logic [1:0] CMD_READ2 = 2'd2;

   localparam logic [1:0] STAT_DONE = 2'd0;
   localparam logic [1:0] STAT_FULL = 2'd1;
   localparam logic [1:0] STAT_NONE = 2'd2;

   localparam logic [3:0] LEAD_MAX = 4'd15;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load_req;
      logic exec;
   } ctrl_type;

   // Datapath to controller.
   typedef struct packed {
      logic rsp_busy;
   } stat_type;

endpackage

/* design/dual_reader_broadcast_queue_top.sv */
// Timing: a request beat is captured in the idle state and runs in the execute state;
// its response is registered and stays valid until taken; execution waits while a
// held response is stalled. No new request is taken while one is in the execute
// state, but a new request is taken while the previous response waits.
// Reset: synchronous, active high; empties the queue, clears the seen flags,
// the lead counter and the response valid.
`timescale 1ns / 1ps

module dual_reader_broadcast_queue_top #(
   parameter int SLOTS = drbq_pkg::SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_send_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_read_value,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_occupancy
);

   drbq_pkg::ctrl_type ctrl;
   drbq_pkg::stat_type stat;

   drbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   drbq_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_cmd        (req_cmd),
      .req_send_value (req_send_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy),
      .ctrl           (ctrl),
      .stat           (stat)
   );

endmodule

/* design/drbq_ctrl.sv */
// Controller of the dual reader broadcast queue.
// Sequences capture and execution of one request beat; uses drbq_pkg.
`timescale 1ns / 1ps

module drbq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  drbq_pkg::stat_type stat,
   output drbq_pkg::ctrl_type ctrl
);

   drbq_pkg::state_type state_ff;
   drbq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= drbq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_stall     = 1'b1;
      ctrl.load_req = 1'b0;
      ctrl.exec     = 1'b0;
      case (state_ff)
         drbq_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctrl.load_req = 1'b1;
               state_in      = drbq_pkg::ST_EXEC;
            end
         end
         drbq_pkg::ST_EXEC: begin
            // The operation waits until the output register can take its result.
            if (!stat.rsp_busy) begin
               ctrl.exec = 1'b1;
               state_in  = drbq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = drbq_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* design/drbq_dpath.sv */
// Datapath of the dual reader broadcast queue: slot array, seen flags,
// lead counter, request register and output register. Uses drbq_pkg.
`timescale 1ns / 1ps

module drbq_dpath #(
   parameter int SLOTS = drbq_pkg::SLOTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         req_cmd,
   input  logic [15:0]        req_send_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_read_value,
   output logic [1:0]         rsp_status,
   output logic [3:0]         rsp_occupancy,
   input  drbq_pkg::ctrl_type ctrl,
   output drbq_pkg::stat_type stat
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);

   // Valid slots are always a contiguous run from slot 0, so a count
   // stands for the valid flags.
   logic [CW-1:0]    count_ff, count_in;
   logic [15:0]      value_ff [SLOTS];
   logic [15:0]      value_in [SLOTS];
   logic [SLOTS-1:0] seen1_ff, seen1_in;
   logic [SLOTS-1:0] seen2_ff, seen2_in;
   logic [3:0]       lead_ff, lead_in;

   logic [1:0]       cmd_ff;
   logic [15:0]      send_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      read_value_ff, read_value_in;
   logic [1:0]       status_ff, status_in;
   logic [3:0]       occ_ff, occ_in;

   logic [SLOTS-1:0] mine, other, cand;
   logic             hit;
   logic [IW-1:0]    hit_idx;
   logic             is_read;
   logic             do_read;
   logic             do_remove;

   assign stat.rsp_busy = rsp_valid_ff && rsp_stall;

   always_comb begin
      mine    = (cmd_ff == drbq_pkg::CMD_READ1) ? seen1_ff : seen2_ff;
      other   = (cmd_ff == drbq_pkg::CMD_READ1) ? seen2_ff : seen1_ff;
      hit     = 1'b0;
      hit_idx = '0;
      for (int k = 0; k < SLOTS; k++) begin
         cand[k] = (CW'(k) < count_ff) && !mine[k];
      end
      // Scan from the top so that the lowest candidate wins.
      for (int k = SLOTS - 1; k >= 0; k--) begin
         if (cand[k]) begin
            hit     = 1'b1;
            hit_idx = IW'(k);
         end
      end
   end

   always_comb begin
      count_in      = count_ff;
      value_in      = value_ff;
      seen1_in      = seen1_ff;
      seen2_in      = seen2_ff;
      lead_in       = lead_ff;
      read_value_in = read_value_ff;
      status_in     = status_ff;
      occ_in        = occ_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      is_read       = (cmd_ff == drbq_pkg::CMD_READ1) || (cmd_ff == drbq_pkg::CMD_READ2);
      do_read       = 1'b0;
      do_remove     = 1'b0;

      if (ctrl.exec) begin
         rsp_valid_in  = 1'b1;
         read_value_in = '0;
         status_in     = drbq_pkg::STAT_DONE;

         case (cmd_ff)
            drbq_pkg::CMD_SEND: begin
               if (count_ff < CW'(SLOTS)) begin
                  value_in[count_ff[IW-1:0]] = send_ff;
                  seen1_in[count_ff[IW-1:0]] = 1'b0;
                  seen2_in[count_ff[IW-1:0]] = 1'b0;
                  count_in = count_ff + 1'b1;
               end else begin
                  status_in = drbq_pkg::STAT_FULL;
               end
            end
            drbq_pkg::CMD_READ1: begin
               if (hit) begin
                  do_read = 1'b1;
                  if (lead_ff != drbq_pkg::LEAD_MAX) begin
                     lead_in = lead_ff + 4'd1;
                  end
               end else begin
                  status_in = drbq_pkg::STAT_NONE;
               end
            end
            drbq_pkg::CMD_READ2: begin
               if (hit && (lead_ff != 4'd0)) begin
                  do_read = 1'b1;
                  lead_in = lead_ff - 4'd1;
               end else begin
                  status_in = drbq_pkg::STAT_NONE;
               end
            end
            default: begin
               status_in = drbq_pkg::STAT_DONE;
            end
         endcase

         if (do_read && is_read) begin
            read_value_in = value_ff[hit_idx];
            do_remove     = other[hit_idx];
            if (!do_remove) begin
               if (cmd_ff == drbq_pkg::CMD_READ1) begin
                  seen1_in[hit_idx] = 1'b1;
               end else begin
                  seen2_in[hit_idx] = 1'b1;
               end
            end else begin
               // Both readers have the entry: compact everything above it down.
               for (int k = 0; k < SLOTS; k++) begin
                  if (IW'(k) >= hit_idx) begin
                     if (k == SLOTS - 1) begin
                        seen1_in[k] = 1'b0;
                        seen2_in[k] = 1'b0;
                     end else begin
                        value_in[k] = value_ff[k + 1];
                        seen1_in[k] = seen1_ff[k + 1];
                        seen2_in[k] = seen2_ff[k + 1];
                     end
                  end
               end
               count_in = count_ff - 1'b1;
            end
         end

         occ_in = 4'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         seen1_ff     <= '0;
         seen2_ff     <= '0;
         lead_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         seen1_ff     <= seen1_in;
         seen2_ff     <= seen2_in;
         lead_ff      <= lead_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      read_value_ff <= read_value_in;
      status_ff     <= status_in;
      occ_ff        <= occ_in;
      if (ctrl.load_req) begin
         cmd_ff  <= req_cmd;
         send_ff <= req_send_value;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = read_value_ff;
   assign rsp_status     = status_ff;
   assign rsp_occupancy  = occ_ff;

endmodule

/* verif/tb_dual_reader_broadcast_queue_top.sv */
// Self-checking testbench for dual_reader_broadcast_queue_top.
// Drives send and read requests through the valid/stall channels and checks every response
// against a two-reader queue predictor in the scoreboard. Needs only drbq_pkg and the top.
`timescale 1ns / 1ps

module tb_dual_reader_broadcast_queue_top;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 1075;

   class queue_scoreboard;
      localparam int DEPTH = drbq_pkg::SLOTS_DEFAULT;

      typedef struct packed {
         logic [15:0] read_value;
         logic [1:0]  status;
         logic [3:0]  occupancy;
      } reply_type;

      logic [15:0] slot_value [DEPTH];
      bit          slot_valid [DEPTH];
      bit          seen_first [DEPTH];
      bit          seen_second [DEPTH];
      logic [3:0]  first_lead;
      reply_type   pending_replies [$];
      int          failures;
      int          requests;
      int          checked;
      int          full_sends;
      int          empty_reads;

      function new();
         for (int k = 0; k < DEPTH; k++) begin
            slot_value[k] = '0;
            slot_valid[k] = 1'b0;
            seen_first[k] = 1'b0;
            seen_second[k] = 1'b0;
         end
         first_lead = '0;
         failures = 0;
         requests = 0;
         checked = 0;
         full_sends = 0;
         empty_reads = 0;
      endfunction

      // The oldest entry this reader has not seen is either marked or, when the other
      // reader already saw it, dropped with everything above it moving down one slot.
      function bit take_oldest(input bit by_second, output logic [15:0] value);
         bit mine;
         bit other;
         value = '0;
         for (int k = 0; k < DEPTH; k++) begin
            mine = by_second ? seen_second[k] : seen_first[k];
            other = by_second ? seen_first[k] : seen_second[k];
            if (slot_valid[k] && !mine) begin
               value = slot_value[k];
               if (other) begin
                  for (int j = k; j < DEPTH - 1; j++) begin
                     slot_value[j] = slot_value[j + 1];
                     slot_valid[j] = slot_valid[j + 1];
                     seen_first[j] = seen_first[j + 1];
                     seen_second[j] = seen_second[j + 1];
                  end
                  slot_value[DEPTH - 1] = '0;
                  slot_valid[DEPTH - 1] = 1'b0;
                  seen_first[DEPTH - 1] = 1'b0;
                  seen_second[DEPTH - 1] = 1'b0;
               end else if (by_second) begin
                  seen_second[k] = 1'b1;
               end else begin
                  seen_first[k] = 1'b1;
               end
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void note_request(input logic [1:0] cmd, input logic [15:0] value);
         reply_type   r;
         logic [15:0] got;
         int          count;
         r = '0;
         r.status = drbq_pkg::STAT_DONE;
         requests++;
         case (cmd)
            drbq_pkg::CMD_SEND: begin
               r.status = drbq_pkg::STAT_FULL;
               for (int k = 0; k < DEPTH; k++) begin
                  if (!slot_valid[k]) begin
                     slot_value[k] = value;
                     slot_valid[k] = 1'b1;
                     seen_first[k] = 1'b0;
                     seen_second[k] = 1'b0;
                     r.status = drbq_pkg::STAT_DONE;
                     break;
                  end
               end
            end
            drbq_pkg::CMD_READ1: begin
               if (take_oldest(1'b0, got)) begin
                  r.read_value = got;
                  if (first_lead != drbq_pkg::LEAD_MAX) first_lead++;
               end else begin
                  r.status = drbq_pkg::STAT_NONE;
               end
            end
            drbq_pkg::CMD_READ2: begin
               r.status = drbq_pkg::STAT_NONE;
               // The second reader only gets a turn while it trails the first one.
               if (first_lead != 0) begin
                  if (take_oldest(1'b1, got)) begin
                     r.read_value = got;
                     r.status = drbq_pkg::STAT_DONE;
                     first_lead--;
                  end
               end
            end
            default: ;
         endcase
         count = 0;
         for (int k = 0; k < DEPTH; k++) count += slot_valid[k];
         r.occupancy = count[3:0];
         if (r.status == drbq_pkg::STAT_FULL) full_sends++;
         if (r.status == drbq_pkg::STAT_NONE) empty_reads++;
         pending_replies.push_back(r);
      endfunction

      function void check_response(input logic [15:0] read_value, input logic [1:0] status,
                                   input logic [3:0] occupancy);
         reply_type want;
         if (pending_replies.size() == 0) begin
            $error("response beat with nothing expected: read_value %h status %0d occupancy %0d",
                   read_value, status, occupancy);
            failures++;
            return;
         end
         want = pending_replies.pop_front();
         checked++;
         if (read_value !== want.read_value) begin
            $error("read_value mismatch: expected %h, actual %h", want.read_value, read_value);
            failures++;
         end
         if (status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status);
            failures++;
         end
         if (occupancy !== want.occupancy) begin
            $error("occupancy mismatch: expected %0d, actual %0d", want.occupancy, occupancy);
            failures++;
         end
      endfunction

      function int pending_count();
         return pending_replies.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_cmd;
   logic [15:0] req_send_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_read_value;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_occupancy;

   int sender_idle_pct;
   int receiver_idle_pct;
   queue_scoreboard sb;

   dual_reader_broadcast_queue_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_send_value (req_send_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

   // Response side: check each accepted beat, then pick the stall for the next cycle.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_response(rsp_read_value, rsp_status, rsp_occupancy);
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // Holds the beat until it is taken; valid stays high when the next beat follows directly.
   task automatic drive_request(input logic [1:0] cmd, input logic [15:0] value);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_send_value <= value;
      do @(posedge clock); while (req_stall);
      sb.note_request(cmd, value);
   endtask

   function automatic logic [15:0] pick_value();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   // Bursts lean toward filling, draining, an even mix or the second reader, so the queue swings
   // between empty and full and the first reader's lead grows and shrinks.
   task automatic run_random(input int count);
      int lean;
      int roll;
      logic [1:0] cmd;
      lean = 0;
      for (int i = 0; i < count; i++) begin
         if (i % 20 == 0) lean = $urandom_range(3);
         roll = $urandom_range(99);
         if (roll < 2) begin
            cmd = CMD_UNUSED;
         end else begin
            case (lean)
               0: cmd = (roll < 70) ? drbq_pkg::CMD_SEND :
                        (roll < 85) ? drbq_pkg::CMD_READ1 : drbq_pkg::CMD_READ2;
               1: cmd = (roll < 25) ? drbq_pkg::CMD_SEND :
                        (roll < 62) ? drbq_pkg::CMD_READ1 : drbq_pkg::CMD_READ2;
               2: cmd = (roll < 40) ? drbq_pkg::CMD_SEND :
                        (roll < 70) ? drbq_pkg::CMD_READ1 : drbq_pkg::CMD_READ2;
               default: cmd = (roll < 35) ? drbq_pkg::CMD_SEND :
                              (roll < 50) ? drbq_pkg::CMD_READ1 : drbq_pkg::CMD_READ2;
            endcase
         end
         drive_request(cmd, pick_value());
      end
   endtask

   initial begin
      sb = new();
      sender_idle_pct = 17;
      receiver_idle_pct = 67;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_cmd <= drbq_pkg::CMD_SEND;
      req_send_value <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty reads, a blocked second reader, the unused command,
      // extreme values, a full queue and removal once both readers are done.
      drive_request(drbq_pkg::CMD_READ1, 16'h1234);
      drive_request(drbq_pkg::CMD_READ2, 16'h4321);
      drive_request(CMD_UNUSED, 16'hBEEF);
      drive_request(drbq_pkg::CMD_SEND, 16'hFFFF);
      drive_request(drbq_pkg::CMD_SEND, 16'h0000);
      drive_request(drbq_pkg::CMD_READ2, 16'h0000);
      drive_request(drbq_pkg::CMD_READ1, 16'h0000);
      drive_request(drbq_pkg::CMD_READ2, 16'hFFFF);
      drive_request(drbq_pkg::CMD_SEND, 16'hAAAA);
      drive_request(drbq_pkg::CMD_SEND, 16'h5555);
      drive_request(drbq_pkg::CMD_SEND, 16'h8001);
      drive_request(drbq_pkg::CMD_SEND, 16'h7FFE);
      drive_request(drbq_pkg::CMD_SEND, 16'h00FF);
      drive_request(drbq_pkg::CMD_SEND, 16'hFF00);
      drive_request(drbq_pkg::CMD_SEND, 16'h0001);
      drive_request(drbq_pkg::CMD_SEND, 16'hC3C3);
      drive_request(drbq_pkg::CMD_READ1, 16'h0000);
      drive_request(drbq_pkg::CMD_READ1, 16'h0000);
      drive_request(drbq_pkg::CMD_READ1, 16'h0000);
      drive_request(drbq_pkg::CMD_READ2, 16'h0000);
      drive_request(drbq_pkg::CMD_READ2, 16'h0000);
      drive_request(drbq_pkg::CMD_READ2, 16'h0000);
      drive_request(drbq_pkg::CMD_READ2, 16'h0000);
      drive_request(CMD_UNUSED, 16'h0000);
      drive_request(drbq_pkg::CMD_SEND, 16'h2468);

      run_random(RANDOM_ITEMS / 3);
      sender_idle_pct = 67;
      receiver_idle_pct = 17;
      run_random(RANDOM_ITEMS / 3);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
      req_valid <= 1'b0;

      while (sb.pending_count() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Run covered %0d requests and checked %0d responses under three idle mixes.",
               sb.requests, sb.checked);
      $display("Sends refused on a full queue: %0d; reads with nothing available: %0d.",
               sb.full_sends, sb.empty_reads);
      if (sb.failures == 0 && sb.pending_count() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
